### hdl/pip_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pip_pkg
// Shared types and codes for the point-in-polygon test core.
// ---------------------------------------------------------------------------
package pip_pkg;

	localparam int COORD_FIELD_W = 16;
	localparam int INDEX_FIELD_W = 6;
	localparam int WIND_FIELD_W  = 8;
	localparam int CFG_INDEX_W   = 1;
	localparam int CFG_DATA_W    = 7;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_TEST = 1'b1
	} pip_cmd_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_TEST_MODE    = 1'b0,
		CFG_VERTEX_COUNT = 1'b1
	} pip_cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_FINISH
	} pip_state_t;

	typedef struct packed {
		logic                            command;
		logic [INDEX_FIELD_W-1:0]        vertex_index;
		logic signed [COORD_FIELD_W-1:0] coord_x;
		logic signed [COORD_FIELD_W-1:0] coord_y;
	} pip_in_t;

	typedef struct packed {
		logic                           inside_res;
		logic signed [WIND_FIELD_W-1:0] winding_number;
	} pip_out_t;

	// per-edge outcome leaving the edge unit
	typedef struct packed {
		logic valid;
		logic inc;
		logic dec;
	} pip_step_t;

endpackage

### hdl/pip_edge_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pip_edge_unit
// Three-stage edge evaluator: crossing direction and exact cross-product
// sign of the test point against one polygon edge, one edge per cycle.
// ---------------------------------------------------------------------------
module pip_edge_unit #(
	parameter int CW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 edge_valid,
	input  logic signed [CW-1:0] ax,
	input  logic signed [CW-1:0] ay,
	input  logic signed [CW-1:0] bx,
	input  logic signed [CW-1:0] by,
	input  logic signed [CW-1:0] px,
	input  logic signed [CW-1:0] py,
	output logic                 busy,
	output pip_pkg::pip_step_t   step
);
	import pip_pkg::*;

	localparam int DW = CW + 1;
	localparam int PW = 2 * DW;
	localparam int SW = PW + 1;

	logic                 v_s1, v_s2;
	logic                 up_s1, dn_s1, up_s2, dn_s2;
	logic signed [DW-1:0] dxb_s1, dyp_s1, dxp_s1, dyb_s1;
	logic signed [PW-1:0] p1_s2, p2_s2;
	logic        [SW-1:0] sd;
	logic                 pos, neg;
	pip_step_t            step_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			step_s3 <= '0;
		end else begin
			v_s1          <= edge_valid;
			v_s2          <= v_s1;
			step_s3.valid <= v_s2;
			step_s3.inc   <= v_s2 & up_s2 & pos;
			step_s3.dec   <= v_s2 & dn_s2 & neg;
		end
	end

	always_ff @(posedge clk) begin
		dxb_s1 <= {bx[CW-1], bx} - {ax[CW-1], ax};
		dyp_s1 <= {py[CW-1], py} - {ay[CW-1], ay};
		dxp_s1 <= {px[CW-1], px} - {ax[CW-1], ax};
		dyb_s1 <= {by[CW-1], by} - {ay[CW-1], ay};
		// upward edge spans the point's row, or downward edge does
		up_s1  <= (ay <= py) && (by > py);
		dn_s1  <= (ay > py) && (by <= py);
		p1_s2  <= dxb_s1 * dyp_s1;
		p2_s2  <= dxp_s1 * dyb_s1;
		up_s2  <= up_s1;
		dn_s2  <= dn_s1;
	end

	assign sd  = {p1_s2[PW-1], p1_s2} - {p2_s2[PW-1], p2_s2};
	assign pos = !sd[SW-1] && (sd != '0);
	assign neg = sd[SW-1];

	assign busy = v_s1 | v_s2 | step_s3.valid;
	assign step = step_s3;

endmodule

### hdl/point_in_polygon_test_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// point_in_polygon_test_core
// Vertex store plus winding-number / crossing-parity point test.
// ---------------------------------------------------------------------------
// Usage:
//   in_data carries a command. A load writes one vertex into the store slot
//   vertex_index and gives no result; loads to slots at or above
//   MAX_VERTICES are dropped. A test walks the closed edge list of the first
//   vertex_count vertices and gives one out_data item.
//   Configuration (test_mode, vertex_count) is written through cfg_we,
//   cfg_index, cfg_data with no wait; write it only while no test is running.
// Timing:
//   a load leaves the core idle, so in_ready stays high for the next item.
//   A test with n >= 3 vertices reads the store once per vertex plus one
//   closing read of vertex 0 over its single read port, one edge per cycle
//   into a three-stage edge unit; the result is registered once the edge
//   unit has drained, and in_ready returns once the result is loaded.
//   With fewer than three vertices the test skips the store walk and goes
//   straight to loading the result. in_ready is low while a test runs.
// Reset and stall:
//   reset sets test_mode to winding mode and vertex_count to zero; store
//   contents stay undefined until loaded. A stalled receiver holds the
//   result in the output register; the next item is still accepted, and a
//   following test waits to finish until the register is free.
// ---------------------------------------------------------------------------
module point_in_polygon_test_core #(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_BITS   = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  pip_pkg::pip_in_t                     in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output pip_pkg::pip_out_t                    out_data,
	input  logic                                 cfg_we,
	input  logic [pip_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [pip_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import pip_pkg::*;

	localparam int IW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int NW   = $clog2(MAX_VERTICES + 1);
	localparam int WW   = NW + 1;
	localparam int LOWB = (COORD_BITS < COORD_FIELD_W) ? COORD_BITS : COORD_FIELD_W;

	pip_state_t state_q, state_d;

	logic                  test_mode_q;
	logic [CFG_DATA_W-1:0] vcount_q;
	logic [NW-1:0]         n_eff, n_q;

	logic [COORD_BITS-1:0]        cx, cy;
	logic signed [COORD_BITS-1:0] px_q, py_q;

	logic [2*COORD_BITS-1:0] mem [MAX_VERTICES];
	logic                    mem_we;
	logic [IW-1:0]           waddr;
	logic                    rd_en;
	logic [IW-1:0]           addr_q;
	logic                    last_q, first_q;
	logic [2*COORD_BITS-1:0] rdata_s1;
	logic                    rd_valid_s1, rd_first_s1;
	logic [2*COORD_BITS-1:0] prev_q;

	logic      edge_valid;
	logic      busy;
	pip_step_t step;

	logic signed [WW-1:0] wn_q;
	logic                 cn_q;
	logic                 accept, test_start, load_out;
	int                   wn_i;
	pip_out_t             res;
	pip_out_t             out_q;
	logic                 out_valid_q;

	assign accept     = in_valid && in_ready;
	assign test_start = accept && (in_data.command == CMD_TEST);
	assign mem_we     = accept && (in_data.command == CMD_LOAD)
	                    && (int'(in_data.vertex_index) < MAX_VERTICES);
	assign waddr      = IW'(in_data.vertex_index);

	// coordinates keep the low COORD_BITS bits of the field
	always_comb begin
		cx = '0;
		cy = '0;
		for (int b = 0; b < LOWB; b++) begin
			cx[b] = in_data.coord_x[b];
			cy[b] = in_data.coord_y[b];
		end
	end

	always_comb begin
		if (int'(vcount_q) > MAX_VERTICES)
			n_eff = NW'(MAX_VERTICES);
		else
			n_eff = NW'(vcount_q);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			test_mode_q <= 1'b1;
			vcount_q    <= '0;
		end else if (cfg_we) begin
			unique case (pip_cfg_idx_t'(cfg_index))
				CFG_TEST_MODE:    test_mode_q <= cfg_data[0];
				CFG_VERTEX_COUNT: vcount_q    <= cfg_data;
				default:          ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		rd_en    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (test_start)
					state_d = (n_eff < NW'(3)) ? ST_FINISH : ST_READ;
			end
			ST_READ: begin
				rd_en = 1'b1;
				if (last_q)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!rd_valid_s1 && !busy)
					state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// read address walk: 0 .. n-1, then 0 again to close the polygon
	always_ff @(posedge clk) begin
		if (test_start) begin
			addr_q  <= '0;
			last_q  <= 1'b0;
			first_q <= 1'b1;
			n_q     <= n_eff;
			px_q    <= cx;
			py_q    <= cy;
		end else if (rd_en) begin
			first_q <= 1'b0;
			if (NW'(addr_q) + NW'(1) == n_q) begin
				addr_q <= '0;
				last_q <= 1'b1;
			end else begin
				addr_q <= addr_q + IW'(1);
			end
		end
	end

	// vertex store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[waddr] <= {cx, cy};
		if (rd_en)
			rdata_s1 <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			rd_first_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			rd_first_s1 <= rd_en && first_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_valid_s1)
			prev_q <= rdata_s1;
	end

	assign edge_valid = rd_valid_s1 && !rd_first_s1;

	pip_edge_unit #(
		.CW (COORD_BITS)
	) u_edge (
		.clk        (clk),
		.arst_n     (arst_n),
		.edge_valid (edge_valid),
		.ax         (prev_q[2*COORD_BITS-1:COORD_BITS]),
		.ay         (prev_q[COORD_BITS-1:0]),
		.bx         (rdata_s1[2*COORD_BITS-1:COORD_BITS]),
		.by         (rdata_s1[COORD_BITS-1:0]),
		.px         (px_q),
		.py         (py_q),
		.busy       (busy),
		.step       (step)
	);

	// winding sum and crossing parity
	always_ff @(posedge clk) begin
		if (test_start) begin
			wn_q <= '0;
			cn_q <= 1'b0;
		end else if (step.valid) begin
			if (step.inc)
				wn_q <= wn_q + WW'(1);
			else if (step.dec)
				wn_q <= wn_q - WW'(1);
			cn_q <= cn_q ^ (step.inc | step.dec);
		end
	end

	always_comb begin
		wn_i = int'(wn_q);
		if (wn_i > 127)
			wn_i = 127;
		if (wn_i < -128)
			wn_i = -128;
		if (!test_mode_q) begin
			res.inside_res     = cn_q;
			res.winding_number = {{(WIND_FIELD_W-1){1'b0}}, cn_q};
		end else begin
			res.inside_res     = (wn_i != 0);
			res.winding_number = WIND_FIELD_W'(wn_i);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out)
			out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// a long enough polygon starts the store walk
	a_test_walks: assert property (@(posedge clk) disable iff (!arst_n)
		test_start && (n_eff >= NW'(3)) |=> state_q == ST_READ)
		else $error("test with enough vertices did not start walking");

	// edge results only come back while a walk is running
	a_step_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		step.valid |-> (state_q == ST_READ) || (state_q == ST_DRAIN))
		else $error("edge step outside a walk");

	// crossing mode gives parity only
	a_parity_out: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && !test_mode_q |=>
			(out_data.winding_number == 8'sd0) || (out_data.winding_number == 8'sd1))
		else $error("crossing mode result is not a parity");

	// a stalled result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !load_out)
		else $error("result loaded over a pending transfer");

endmodule

### bench/tb_point_in_polygon_test_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_point_in_polygon_test_core
// Self-checking bench for the point-in-polygon test core: loads polygons,
// runs point tests in both test modes over many vertex counts, and compares
// every result with an exact integer winding / crossing computation.
// ---------------------------------------------------------------------------
module tb_point_in_polygon_test_core;
	import pip_pkg::*;

	localparam int MAX_VERTS = 64;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	pip_in_t  in_data;
	logic     out_valid;
	logic     out_ready;
	pip_out_t out_data;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// bench copy of the block state
	logic signed [COORD_FIELD_W-1:0] vert_x [MAX_VERTS];
	logic signed [COORD_FIELD_W-1:0] vert_y [MAX_VERTS];
	logic                            cur_mode;
	logic [CFG_DATA_W-1:0]           cur_count;

	pip_out_t expected_results [$];
	int       fail_count;
	int       items_sent;
	bit       stall_en;

	point_in_polygon_test_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("FAILURE");
		$finish;
	end

	always @(posedge clk) begin
		out_ready <= stall_en ? ($urandom_range(99) >= 28) : 1'b1;
	end

	// exact winding / crossing count of the point against the stored edges
	function automatic pip_out_t predict_point_test(input logic signed [15:0] px,
			input logic signed [15:0] py);
		int       n, wn, cn, nxt;
		longint   ax, ay, bx, by, qx, qy, cr;
		pip_out_t r;
		n  = (cur_count > MAX_VERTS) ? MAX_VERTS : cur_count;
		wn = 0;
		cn = 0;
		qx = px;
		qy = py;
		if (n >= 3) begin
			for (int i = 0; i < n; i++) begin
				nxt = (i + 1 == n) ? 0 : i + 1;
				ax = vert_x[i];
				ay = vert_y[i];
				bx = vert_x[nxt];
				by = vert_y[nxt];
				cr = (bx - ax) * (qy - ay) - (qx - ax) * (by - ay);
				if (ay <= qy) begin
					if (by > qy && cr > 0) begin
						wn++;
						cn++;
					end
				end else if (by <= qy && cr < 0) begin
					wn--;
					cn++;
				end
			end
		end
		if (cur_mode == 1'b0) begin
			r.inside_res     = cn[0];
			r.winding_number = {7'd0, cn[0]};
		end else begin
			if (wn > 127) wn = 127;
			if (wn < -128) wn = -128;
			r.inside_res     = (wn != 0);
			r.winding_number = wn[7:0];
		end
		return r;
	endfunction

	// sampled at the falling edge so the values are settled for the next rising edge
	always @(negedge clk) begin : check_results
		pip_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result with no test pending: inside_res %0d winding_number %0d",
					out_data.inside_res, out_data.winding_number);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (out_data.inside_res !== want.inside_res) begin
					$error("inside_res expected %0d actual %0d",
						want.inside_res, out_data.inside_res);
					fail_count++;
				end
				if (out_data.winding_number !== want.winding_number) begin
					$error("winding_number expected %0d actual %0d",
						want.winding_number, out_data.winding_number);
					fail_count++;
				end
			end
		end
	end

	task automatic send_item(input pip_in_t item);
		bit took;
		if (stall_en && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (stall_en && $urandom_range(99) < 28);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		items_sent++;
		if (item.command == CMD_LOAD) begin
			vert_x[item.vertex_index] = item.coord_x;
			vert_y[item.vertex_index] = item.coord_y;
		end else begin
			expected_results.insert(expected_results.size(),
				predict_point_test(item.coord_x, item.coord_y));
		end
	endtask

	task automatic load_vertex(input int slot, input logic signed [15:0] x,
			input logic signed [15:0] y);
		pip_in_t item;
		item.command      = CMD_LOAD;
		item.vertex_index = slot[INDEX_FIELD_W-1:0];
		item.coord_x      = x;
		item.coord_y      = y;
		send_item(item);
	endtask

	task automatic test_point(input logic signed [15:0] x, input logic signed [15:0] y);
		pip_in_t item;
		item.command      = CMD_TEST;
		item.vertex_index = INDEX_FIELD_W'($urandom);
		item.coord_x      = x;
		item.coord_y      = y;
		send_item(item);
	endtask

	// hold off input until every pending result has been taken, then let loads settle
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_cfg(input pip_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_TEST_MODE) cur_mode = val[0];
		else cur_count = val;
	endtask

	function automatic logic signed [15:0] rand_coord(input int span);
		int v;
		if (span == 0) v = $urandom;
		else v = int'($urandom_range(2 * span)) - span;
		return v[15:0];
	endfunction

	// fills slots 0..n-1 in shuffled order; wound repeats a square n/4 times
	task automatic load_polygon(input int n, input bit wound, input int span);
		int  order [MAX_VERTS];
		int  j, tmp, a, k;
		bit  cw;
		logic signed [15:0] xs [MAX_VERTS];
		logic signed [15:0] ys [MAX_VERTS];
		cw = 1'($urandom_range(1));
		a  = (span == 0) ? 32767 : span;
		for (int i = 0; i < n; i++) begin
			order[i] = i;
			if (wound) begin
				k     = cw ? 3 - (i % 4) : i % 4;
				xs[i] = 16'((k == 0 || k == 3) ? -a : a);
				ys[i] = 16'((k < 2) ? -a : a);
			end else begin
				xs[i] = rand_coord(span);
				ys[i] = rand_coord(span);
			end
		end
		for (int i = n - 1; i > 0; i--) begin
			j        = $urandom_range(i);
			tmp      = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 0; i < n; i++) load_vertex(order[i], xs[order[i]], ys[order[i]]);
	endtask

	// points on vertices, edges and vertex rows as well as free ones
	task automatic random_test(input int n, input int span);
		int s, t;
		logic signed [15:0] x, y;
		s = (n > 0) ? $urandom_range(n - 1) : 0;
		t = (s + 1 >= n) ? 0 : s + 1;
		x = rand_coord(span);
		y = rand_coord(span);
		case ($urandom_range(6))
			0: begin
				x = rand_coord(0);
				y = rand_coord(0);
			end
			1: begin
				x = vert_x[s];
				y = vert_y[s];
			end
			2: y = vert_y[s];
			3: begin
				x = 16'((longint'(vert_x[s]) + longint'(vert_x[t])) >>> 1);
				y = 16'((longint'(vert_y[s]) + longint'(vert_y[t])) >>> 1);
			end
			4: begin
				x = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
				y = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			end
			default: ;
		endcase
		test_point(x, y);
	endtask

	task automatic test_reset_state();
		// winding mode and no vertices straight out of reset
		test_point(16'sd0, 16'sd0);
		test_point(16'sh7fff, 16'sh8000);
	endtask

	task automatic test_few_vertices();
		load_vertex(0, 16'sh8000, 16'sh8000);
		load_vertex(1, 16'sh7fff, 16'sh8000);
		load_vertex(2, 16'sd0, 16'sh7fff);
		write_cfg(CFG_VERTEX_COUNT, 7'd1);
		test_point(16'sd0, 16'sd0);
		write_cfg(CFG_VERTEX_COUNT, 7'd2);
		test_point(16'sd0, 16'sd0);
		write_cfg(CFG_VERTEX_COUNT, 7'd3);
		test_point(16'sd0, 16'sd0);
		test_point(16'sh8000, 16'sh7fff);
		test_point(16'sd0, 16'sh8000);
		write_cfg(CFG_TEST_MODE, 7'd0);
		test_point(16'sd0, 16'sd0);
		test_point(16'sh7fff, 16'sh8000);
	endtask

	task automatic test_square();
		load_vertex(0, -16'sd100, -16'sd100);
		load_vertex(1, 16'sd100, -16'sd100);
		load_vertex(2, 16'sd100, 16'sd100);
		load_vertex(3, -16'sd100, 16'sd100);
		write_cfg(CFG_VERTEX_COUNT, 7'd4);
		test_point(16'sd0, 16'sd0);
		test_point(16'sd100, 16'sd0);
		test_point(-16'sd100, 16'sd0);
		test_point(16'sd0, 16'sd100);
		test_point(16'sd100, 16'sd100);
		test_point(16'sd200, 16'sd0);
		// ray grazing the bottom vertex row
		test_point(-16'sd200, -16'sd100);
		write_cfg(CFG_TEST_MODE, 7'd1);
		test_point(16'sd0, 16'sd0);
		test_point(-16'sd100, 16'sd0);
	endtask

	// whole store as a many-times-wound square, also covers count saturation
	task automatic test_wound_store();
		int a;
		a = $urandom_range(1000, 32767);
		load_polygon(MAX_VERTS, 1'b1, a);
		write_cfg(CFG_VERTEX_COUNT, 7'd64);
		test_point(16'sd0, 16'sd0);
		test_point(a[15:0], 16'sd0);
		test_point(16'sd0, 16'sh7fff);
		write_cfg(CFG_VERTEX_COUNT, 7'd127);
		test_point(16'sd0, 16'sd0);
		test_point(-16'sd1, 16'sd1);
		write_cfg(CFG_TEST_MODE, 7'd0);
		test_point(16'sd0, 16'sd0);
		write_cfg(CFG_VERTEX_COUNT, 7'd65);
		test_point(16'sd0, 16'sd0);
	endtask

	task automatic test_random_polygons(input int target);
		int n, span, r, phase;
		bit wound;
		logic [CFG_DATA_W-1:0] count;
		phase = 0;
		while (items_sent < target) begin
			stall_en = !(phase >= 8 && phase < 16);
			r = $urandom_range(99);
			if (r < 8) n = $urandom_range(2);
			else if (r < 18) n = $urandom_range(13, MAX_VERTS);
			else n = $urandom_range(3, 12);
			wound = ($urandom_range(3) == 0);
			case ($urandom_range(3))
				0: span = 0;
				1: span = $urandom_range(1, 8);
				2: span = $urandom_range(9, 1000);
				default: span = 32767;
			endcase
			load_polygon(n, wound, span);
			count = CFG_DATA_W'(n);
			if (n == MAX_VERTS && $urandom_range(1))
				count = CFG_DATA_W'($urandom_range(64, 127));
			write_cfg(CFG_VERTEX_COUNT, count);
			write_cfg(CFG_TEST_MODE, CFG_DATA_W'($urandom_range(1)));
			repeat ($urandom_range(4, 24)) begin
				// the odd load in between overwrites live or spare slots
				if ($urandom_range(19) == 0)
					load_vertex($urandom_range(MAX_VERTS - 1), rand_coord(span),
						rand_coord(span));
				else
					random_test(n, span);
			end
			phase++;
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		out_ready  = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = CFG_TEST_MODE;
		cfg_data   = '0;
		cur_mode   = 1'b1;
		cur_count  = '0;
		fail_count = 0;
		items_sent = 0;
		stall_en   = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_few_vertices();
		test_square();
		test_wound_store();
		test_random_polygons(1250);
		drain_results();
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
